[rtl/mml_pkg.sv]
package mml_pkg;

  // Longest token length that the length counter reports before it saturates.
  localparam int MaxTokenLength = 255;
  localparam int LenLimitInt    = (MaxTokenLength > 255) ? 255 : MaxTokenLength;
  localparam logic [7:0] LenLimit = 8'(LenLimitInt);

  // Depth of the queue between the automaton and the output port.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    KindIdent  = 3'd0,
    KindLit    = 3'd1,
    KindDelim  = 3'd2,
    KindPrefix = 3'd3,
    KindInfix  = 3'd4,
    KindError  = 3'd5
  } token_kind_e;

  // One result word.
  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  len;
  } result_t;

  // The results that one input word causes: one, or two when two is set.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } result_pair_t;

endpackage

[rtl/mml_in_if.sv]
interface mml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink (input valid, input symbol, input end_of_text, output ready);
endinterface

[rtl/mml_out_if.sv]
interface mml_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_length;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_length,
                input last_of_run, output ready);
endinterface

[rtl/mml_front.sv]
module mml_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mml_in_if.sink                in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output mml_pkg::result_pair_t pair_o
);
  import mml_pkg::*;

  typedef enum logic [10:0] {
    StStart  = 11'b00000000001,
    StLt     = 11'b00000000010,
    StEq     = 11'b00000000100,
    StIdent  = 11'b00000001000,
    StLit    = 11'b00000010000,
    StDelim  = 11'b00000100000,
    StPrefix = 11'b00001000000,
    StSingle = 11'b00010000000,
    StLe     = 11'b00100000000,
    StLeg    = 11'b01000000000,
    StArrow  = 11'b10000000000
  } lex_state_e;

  typedef struct packed {
    logic       trap;
    lex_state_e state;
  } lex_step_t;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;

  // One move of the automaton; trap means the character has no move.
  function automatic lex_step_t step(lex_state_e st, logic [7:0] c);
    lex_step_t r;
    r.trap  = 1'b0;
    r.state = StStart;
    case (st)
      StStart: begin
        if (c inside {[ChLowA:ChLowZ]}) r.state = StIdent;
        else if (c inside {ChZero, ChOne}) r.state = StLit;
        else if (c inside {ChLParen, ChRParen}) r.state = StDelim;
        else if (c == ChBang) r.state = StPrefix;
        else if (c inside {ChStar, ChPlus}) r.state = StSingle;
        else if (c == ChLt) r.state = StLt;
        else if (c == ChEq) r.state = StEq;
        else r.trap = 1'b1;
      end
      StIdent: begin
        if (c inside {[ChLowA:ChLowZ], [ChZero:ChNine]}) r.state = StIdent;
        else r.trap = 1'b1;
      end
      StLt: begin
        if (c == ChEq) r.state = StLe;
        else r.trap = 1'b1;
      end
      StLe: begin
        if (c == ChGt) r.state = StLeg;
        else r.trap = 1'b1;
      end
      StEq: begin
        if (c == ChGt) r.state = StArrow;
        else r.trap = 1'b1;
      end
      default: begin
        r.trap = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Token kind of an accepting state; any other state reports an error.
  function automatic token_kind_e kind_of(lex_state_e st);
    token_kind_e k;
    case (st)
      StIdent:                      k = KindIdent;
      StLit:                        k = KindLit;
      StDelim:                      k = KindDelim;
      StPrefix:                     k = KindPrefix;
      StSingle, StLe, StLeg, StArrow: k = KindInfix;
      default:                      k = KindError;
    endcase
    return k;
  endfunction

  lex_state_e   state_q, state_d;
  logic [7:0]   len_q, len_d;
  lex_step_t    cont, fresh;
  result_t      pending;
  result_pair_t pair;
  logic         emit;
  logic         accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // The current character tried both as a continuation and as a fresh start.
  assign cont  = step(state_q, in_i.symbol);
  assign fresh = step(StStart, in_i.symbol);

  // Report of the pending attempt, with length zero for an error.
  always_comb begin
    pending.kind = kind_of(state_q);
    pending.len  = (pending.kind == KindError) ? 8'd0 : len_q;
  end

  // Next automaton state and the results this word causes.
  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    emit          = 1'b0;
    pair.two      = 1'b0;
    pair.first    = pending;
    pair.second.kind = KindError;
    pair.second.len  = 8'd0;
    if (in_i.end_of_text) begin
      if (state_q != StStart) begin
        emit    = 1'b1;
        state_d = StStart;
        len_d   = 8'd0;
      end
    end else if (state_q == StStart) begin
      if (fresh.trap) begin
        emit             = 1'b1;
        pair.first.kind  = KindError;
        pair.first.len   = 8'd0;
      end else begin
        state_d = fresh.state;
        len_d   = 8'd1;
      end
    end else if (!cont.trap) begin
      state_d = cont.state;
      if (len_q < LenLimit) begin
        len_d = len_q + 8'd1;
      end
    end else begin
      // Report the attempt, then restart on this character.
      emit = 1'b1;
      if (fresh.trap) begin
        pair.two = 1'b1;
        state_d  = StStart;
        len_d    = 8'd0;
      end else begin
        state_d = fresh.state;
        len_d   = 8'd1;
      end
    end
  end

  assign push_o = accept && emit;
  assign pair_o = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
      len_q   <= 8'd0;
    end else if (accept) begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

endmodule

[rtl/mml_fifo.sv]
module mml_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mml_pkg::result_pair_t wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output mml_pkg::result_pair_t rdata_o,
  output logic                  empty_o
);
  import mml_pkg::*;

  result_pair_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]         count_q;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Entry storage; entries are only read after they are written.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

endmodule

[rtl/mml_back.sv]
module mml_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mml_pkg::result_pair_t pair_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  mml_out_if.source             out_o
);
  import mml_pkg::*;

  result_pair_t entry_q;
  logic         valid_q;
  logic         second_q;
  logic         take;
  logic         done;
  logic         load;
  result_t      cur;

  // A word leaves; the entry is done after its last result.
  assign take  = valid_q && out_o.ready;
  assign done  = take && (second_q || !entry_q.two);
  assign load  = (!valid_q || done) && !empty_i;
  assign pop_o = load;

  assign cur                = second_q ? entry_q.second : entry_q.first;
  assign out_o.valid        = valid_q;
  assign out_o.token_kind   = cur.kind;
  assign out_o.token_length = cur.len;
  assign out_o.last_of_run  = second_q || !entry_q.two;

  // Output entry register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= pair_i;
    end
  end

  // Output valid and the result select within the entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      valid_q  <= 1'b1;
      second_q <= 1'b0;
    end else if (done) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (take) begin
      second_q <= 1'b1;
    end
  end

endmodule

[rtl/maximal_munch_token_lexer.sv]
// Path: a result word is written into the queue on the edge that accepts its character,
// then loaded into the output entry register, which drives the output port.
// Throughput: one character per cycle while the queue is not full; a character that causes
// two results holds the output port for both; the four-entry queue absorbs it, then stalls.
// The output port, one result word per cycle while ready is high, sets the sustained rate.
// Reset (rst_ni low, asynchronous): automaton at start, length zero, queue empty.
module maximal_munch_token_lexer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mml_in_if.sink    in_i,
  mml_out_if.source out_o
);
  import mml_pkg::*;

  result_pair_t wr_pair;
  result_pair_t rd_pair;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;

  // Automaton and result building.
  mml_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .pair_o (wr_pair)
  );

  // Queue of result entries.
  mml_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_pair),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rd_pair),
    .empty_o (empty)
  );

  // Output serializer.
  mml_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (rd_pair),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // The queue is never written when full nor read when empty.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("result queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("result queue read while empty");

  // An error result carries length zero.
  a_error_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.token_kind == KindError) |-> (out_o.token_length == 8'd0))
    else $error("error result with nonzero length");

  // The result after a non-final one is the final error of the same character.
  a_second_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_of_run) |=>
    (out_o.valid && out_o.last_of_run && out_o.token_kind == KindError))
    else $error("second result of a character is not a final error");

endmodule
